/* rtl/mstu_pkg.sv */
// Package for the MCP / SCAD threshold update unit: widths, mode codes,
// clip limits and the control struct that travels down the pipeline.
// No dependencies.
package mstu_pkg;

  localparam int NUM_W   = 36;  // numerator magnitude, up to 27*|z|
  localparam int DEN_W   = 36;  // divisor, up to 17*v
  localparam int QUO_W   = 32;  // quotient bits produced by the divider
  localparam int FRONT_STAGES = 3;
  localparam int BACK_STAGES  = 1;
  localparam int LATENCY = FRONT_STAGES + QUO_W + BACK_STAGES;

  localparam logic MODE_MCP  = 1'b0;
  localparam logic MODE_SCAD = 1'b1;

  localparam logic [31:0] LIM_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] LIM_NEG = 32'h8000_0000;

  typedef struct packed {
    logic valid;
    logic neg;    // sign of z
    logic vzero;  // scale was zero
    logic nzero;  // numerator was zero
    logic ovf;    // quotient is at least 2^32
  } mstu_ctl_t;

endpackage

/* rtl/mcp_scad_threshold_update_unit.sv */
// Top level of the MCP / SCAD threshold update unit.
// Depends on mstu_pkg, mstu_front, mstu_div_stage and mstu_back.
//
// Takes one item per clock: start with mode, z_value and scale_v is
// accepted whenever busy is low, and busy is high only during reset. Each
// item returns exactly one result through 3 setup stages, 32
// restoring-division stages and 1 output stage, shown on coef_out and
// saturated for a single cycle while done is high. The
// receiver cannot stall, and nothing inside ever stalls, so a full stream
// of one item per cycle comes out as a full stream one per cycle. The
// result is beta = threshold(z) / v in signed fixed point with FRAC_BITS
// fraction bits, truncated toward zero. Mode 0 selects MCP (gamma 3), mode
// 1 selects SCAD (gamma 3.7). A zero scale or an out-of-range quotient
// clips to the nearest limit and raises saturated; a zero-scale item with
// a zero thresholded value returns 0. Lambda is written through the cfg
// channel, which is ready whenever reset is low; write it only while no
// item is in flight, since each item samples lambda when it is taken.
module mcp_scad_threshold_update_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               mode,
  input  logic signed [31:0] z_value,
  input  logic [30:0]        scale_v,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [30:0]        lambda_penalty,
  output logic               done,
  output logic signed [31:0] coef_out,
  output logic               saturated
);

  localparam int STEPS = mstu_pkg::QUO_W;

  // Hold off items and config writes only while reset is applied.
  assign busy      = rst;
  assign cfg_ready = ~rst;

  logic [30:0] lam;

  always_ff @(posedge clk) begin
    if (rst) begin
      lam <= 31'd0;
    end else if (cfg_valid && cfg_ready) begin
      lam <= lambda_penalty;
    end
  end

  // Division pipeline: element 0 is the front end output, element k the
  // output of division step k.
  mstu_pkg::mstu_ctl_t        ctl [STEPS+1];
  logic [mstu_pkg::DEN_W-1:0] rem [STEPS+1];
  logic [mstu_pkg::DEN_W-1:0] dvs [STEPS+1];
  logic [mstu_pkg::QUO_W-1:0] lo  [STEPS+1];
  logic [mstu_pkg::QUO_W-1:0] quo [STEPS+1];

  mstu_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(start && !busy),
    .in_mode (mode),
    .in_z    (z_value),
    .in_v    (scale_v),
    .lam     (lam),
    .out_ctl (ctl[0]),
    .out_rem (rem[0]),
    .out_d   (dvs[0]),
    .out_lo  (lo[0])
  );

  // Quotient bits start empty and fill from the bottom, one per step.
  assign quo[0] = '0;

  for (genvar k = 0; k < STEPS; k++) begin : g_div
    mstu_div_stage u_step (
      .clk    (clk),
      .rst    (rst),
      .in_ctl (ctl[k]),
      .in_rem (rem[k]),
      .in_d   (dvs[k]),
      .in_lo  (lo[k]),
      .in_q   (quo[k]),
      .out_ctl(ctl[k+1]),
      .out_rem(rem[k+1]),
      .out_d  (dvs[k+1]),
      .out_lo (lo[k+1]),
      .out_q  (quo[k+1])
    );
  end

  // Clip, restore the sign and present the result for one cycle.
  mstu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_ctl   (ctl[STEPS]),
    .in_q     (quo[STEPS]),
    .done     (done),
    .coef_out (coef_out),
    .saturated(saturated)
  );

  // Every result traces back to an item taken exactly one latency earlier.
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, mstu_pkg::LATENCY))
    else $error("result without a matching item");

  // A zero scale always flags saturation on its result.
  a_vzero_flags: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && !busy && (scale_v == 31'd0), mstu_pkg::LATENCY))
      |-> saturated)
    else $error("zero scale not flagged");

  // A flagged result sits at a clip limit or at zero.
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (coef_out == mstu_pkg::LIM_POS ||
                             coef_out == mstu_pkg::LIM_NEG ||
                             coef_out == 32'sd0))
    else $error("saturated result off the limits");

endmodule

/* rtl/mstu_front.sv */
// Front end of the threshold update unit: magnitude of z, branch selection
// and numerator / divisor setup over three register stages.
// Depends on mstu_pkg.
module mstu_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_mode,
  input  logic signed [31:0]         in_z,
  input  logic [30:0]                in_v,
  input  logic [30:0]                lam,
  output mstu_pkg::mstu_ctl_t        out_ctl,
  output logic [mstu_pkg::DEN_W-1:0] out_rem,
  output logic [mstu_pkg::DEN_W-1:0] out_d,
  output logic [mstu_pkg::QUO_W-1:0] out_lo
);

  localparam int SH_W = mstu_pkg::NUM_W + FRAC_BITS;
  localparam int HI_W = SH_W - mstu_pkg::QUO_W;

  // stage A
  logic        a_valid;
  logic        a_mode;
  logic        a_neg;
  logic [31:0] a_az;
  logic [30:0] a_lam;
  logic [30:0] a_v;

  logic [31:0] z_u;
  logic [31:0] az_next;

  assign z_u     = in_z;
  assign az_next = z_u[31] ? (~z_u + 32'd1) : z_u;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_mode <= in_mode;
    a_neg  <= z_u[31];
    a_az   <= az_next;
    a_lam  <= lam;
    a_v    <= in_v;
  end

  // stage B: branch compares and candidate numerators
  logic [32:0] lam3;
  logic [34:0] az10;
  logic [36:0] lam37;
  logic [35:0] az27;
  logic [36:0] scad_diff;
  logic [35:0] d17;

  assign lam3      = {2'b0, a_lam} + {1'b0, a_lam, 1'b0};
  assign az10      = {a_az, 3'b0} + {2'b0, a_az, 1'b0};
  assign lam37     = {1'b0, a_lam, 5'b0} + {4'b0, a_lam, 2'b0} + {6'b0, a_lam};
  assign az27      = {a_az, 4'b0} + {1'b0, a_az, 3'b0} + {3'b0, a_az, 1'b0}
                   + {4'b0, a_az};
  assign scad_diff = {1'b0, az27} - lam37;
  assign d17       = {1'b0, a_v, 4'b0} + {5'b0, a_v};

  logic        b_valid;
  logic        b_mode;
  logic        b_neg;
  logic [31:0] b_az;
  logic        b_le3;
  logic        b_gt1;
  logic        b_le2;
  logic        b_gt37;
  logic [31:0] b_nsoft;
  logic [35:0] b_nscad;
  logic [30:0] b_v;
  logic [35:0] b_d17;
  logic        b_vzero;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_mode  <= a_mode;
    b_neg   <= a_neg;
    b_az    <= a_az;
    b_le3   <= {1'b0, a_az} <= lam3;
    b_gt1   <= a_az > {1'b0, a_lam};
    b_le2   <= {1'b0, a_az} <= {1'b0, a_lam, 1'b0};
    b_gt37  <= {2'b0, az10} > lam37;
    b_nsoft <= a_az - {1'b0, a_lam};
    b_nscad <= scad_diff[35:0];
    b_v     <= a_v;
    b_d17   <= d17;
    b_vzero <= (a_v == 31'd0);
  end

  // stage C: pick numerator and divisor, check for quotient overflow
  logic [33:0]                nmcp;
  logic [mstu_pkg::NUM_W-1:0] num;
  logic [mstu_pkg::DEN_W-1:0] den;
  logic [SH_W-1:0]            nsh;
  logic [HI_W-1:0]            hi;

  assign nmcp = {2'b0, b_nsoft} + {1'b0, b_nsoft, 1'b0};

  always_comb begin
    num = '0;
    den = '0;
    case (b_mode)
      mstu_pkg::MODE_MCP: begin
        if (b_le3) begin
          num = b_gt1 ? mstu_pkg::NUM_W'(nmcp) : '0;
          den = {4'b0, b_v, 1'b0};
        end else begin
          num = mstu_pkg::NUM_W'(b_az);
          den = mstu_pkg::DEN_W'(b_v);
        end
      end
      mstu_pkg::MODE_SCAD: begin
        if (b_le2) begin
          num = b_gt1 ? mstu_pkg::NUM_W'(b_nsoft) : '0;
          den = mstu_pkg::DEN_W'(b_v);
        end else if (b_gt37) begin
          num = mstu_pkg::NUM_W'(b_az);
          den = mstu_pkg::DEN_W'(b_v);
        end else begin
          num = b_nscad;
          den = b_d17;
        end
      end
      default: begin
        num = '0;
        den = '0;
      end
    endcase
  end

  assign nsh = {num, {FRAC_BITS{1'b0}}};
  assign hi  = nsh[SH_W-1:mstu_pkg::QUO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl.valid <= b_valid;
    end
    out_ctl.neg   <= b_neg;
    out_ctl.vzero <= b_vzero;
    out_ctl.nzero <= (num == '0);
    out_ctl.ovf   <= mstu_pkg::DEN_W'(hi) >= den;
    out_rem       <= mstu_pkg::DEN_W'(hi);
    out_d         <= den;
    out_lo        <= nsh[mstu_pkg::QUO_W-1:0];
  end

endmodule

/* rtl/mstu_div_stage.sv */
// One restoring-division step of the threshold update unit: shifts in one
// dividend bit and produces one quotient bit per register stage.
// Depends on mstu_pkg.
module mstu_div_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  mstu_pkg::mstu_ctl_t        in_ctl,
  input  logic [mstu_pkg::DEN_W-1:0] in_rem,
  input  logic [mstu_pkg::DEN_W-1:0] in_d,
  input  logic [mstu_pkg::QUO_W-1:0] in_lo,
  input  logic [mstu_pkg::QUO_W-1:0] in_q,
  output mstu_pkg::mstu_ctl_t        out_ctl,
  output logic [mstu_pkg::DEN_W-1:0] out_rem,
  output logic [mstu_pkg::DEN_W-1:0] out_d,
  output logic [mstu_pkg::QUO_W-1:0] out_lo,
  output logic [mstu_pkg::QUO_W-1:0] out_q
);

  logic [mstu_pkg::DEN_W:0]   trial;
  logic [mstu_pkg::DEN_W+1:0] diff;
  logic                       take;

  assign trial = {in_rem, in_lo[mstu_pkg::QUO_W-1]};
  assign diff  = {1'b0, trial} - {2'b0, in_d};
  assign take  = ~diff[mstu_pkg::DEN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl.valid <= in_ctl.valid;
    end
    out_ctl.neg   <= in_ctl.neg;
    out_ctl.vzero <= in_ctl.vzero;
    out_ctl.nzero <= in_ctl.nzero;
    out_ctl.ovf   <= in_ctl.ovf;
    out_rem       <= take ? diff[mstu_pkg::DEN_W-1:0] : trial[mstu_pkg::DEN_W-1:0];
    out_d         <= in_d;
    out_lo        <= {in_lo[mstu_pkg::QUO_W-2:0], 1'b0};
    out_q         <= {in_q[mstu_pkg::QUO_W-2:0], take};
  end

endmodule

/* rtl/mstu_back.sv */
// Back end of the threshold update unit: zero-scale and overflow clipping,
// sign restore and the registered result.
// Depends on mstu_pkg.
module mstu_back (
  input  logic                       clk,
  input  logic                       rst,
  input  mstu_pkg::mstu_ctl_t        in_ctl,
  input  logic [mstu_pkg::QUO_W-1:0] in_q,
  output logic                       done,
  output logic signed [31:0]         coef_out,
  output logic                       saturated
);

  logic [31:0] limit;
  logic [31:0] mag;
  logic        sat;

  assign limit = in_ctl.neg ? mstu_pkg::LIM_NEG : mstu_pkg::LIM_POS;

  always_comb begin
    if (in_ctl.vzero) begin
      sat = 1'b1;
      mag = in_ctl.nzero ? 32'd0 : limit;
    end else if (in_ctl.ovf || (in_q > limit)) begin
      sat = 1'b1;
      mag = limit;
    end else begin
      sat = 1'b0;
      mag = in_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_ctl.valid;
    end
    coef_out  <= in_ctl.neg ? (~mag + 32'd1) : mag;
    saturated <= sat;
  end

endmodule
